>>> rtl/core/rxbcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rxbcf_pkg
// Shared types and constants of the receive buffer with congestion feedback.
// ----------------------------------------------------------------------------
package rxbcf_pkg;

   localparam int TAG_W   = 32;
   localparam int DUR_W   = 16;
   localparam int LEVEL_W = 8;
   localparam int KIND_W  = 2;
   localparam int LIMIT_W = 9;
   localparam int ARR_W   = 9;

   // Event kinds on the request side
   localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FB      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SERVICE = 2'd2;

   // Actions on the response side
   localparam logic [KIND_W-1:0] ACT_FB_SENT   = 2'd0;
   localparam logic [KIND_W-1:0] ACT_DATA_SENT = 2'd1;
   localparam logic [KIND_W-1:0] ACT_DROPPED   = 2'd2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd200;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 8'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_MIN   = 8'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'd255;
   localparam logic [ARR_W-1:0]   ARR_MAX     = 9'd511;

   typedef struct packed {
      logic [LEVEL_W-1:0] level_in;
      logic [DUR_W-1:0]   duration;
      logic [TAG_W-1:0]   packet_tag;
      logic [KIND_W-1:0]  kind;
   } item_type;

   typedef struct packed {
      logic capture;   // latch the accepted item
      logic commit;    // apply the item's effects, load the result if any
   } cmd_type;

   typedef struct packed {
      logic need_result;  // current item produces a result
      logic out_free;     // result register can take a new item this cycle
   } status_type;

endpackage : rxbcf_pkg
`default_nettype wire

>>> rtl/core/rxbcf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rxbcf_ctrl
// Two-state sequencer: accept an item, then commit it once it yields no
// result or the result register has room.
// ----------------------------------------------------------------------------
module rxbcf_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  rxbcf_pkg::status_type status,
   output rxbcf_pkg::cmd_type    cmd
);
   import rxbcf_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic commit;

   assign req_tready = (state_ff == ST_IDLE);
   // hold in execute while a result is due and the output is still occupied
   assign commit = (state_ff == ST_EXEC) && (!status.need_result || status.out_free);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.capture = req_tvalid && req_tready;
   assign cmd.commit  = commit;

endmodule : rxbcf_ctrl
`default_nettype wire

>>> rtl/core/rxbcf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rxbcf_datapath
// Data and feedback queues, congestion check, service level and result
// register.
// ----------------------------------------------------------------------------
module rxbcf_datapath #(
   parameter int DATA_DEPTH     = 256,
   parameter int FEEDBACK_DEPTH = 16
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_wr_en,
   input  wire  [rxbcf_pkg::LIMIT_W-1:0]  csr_wr_data,
   input  rxbcf_pkg::item_type            item,
   input  rxbcf_pkg::cmd_type             cmd,
   output rxbcf_pkg::status_type          status,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [rxbcf_pkg::KIND_W-1:0]   rsp_action,
   output logic [rxbcf_pkg::TAG_W-1:0]    rsp_tag,
   output logic [rxbcf_pkg::DUR_W-1:0]    rsp_ticks,
   output logic [rxbcf_pkg::LEVEL_W-1:0]  rsp_level
);
   import rxbcf_pkg::*;

   localparam int DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
   localparam int DCW = $clog2(DATA_DEPTH + 1);
   localparam int FAW = (FEEDBACK_DEPTH > 1) ? $clog2(FEEDBACK_DEPTH) : 1;
   localparam int FCW = $clog2(FEEDBACK_DEPTH + 1);
   localparam int CW  = (DCW > LIMIT_W) ? DCW : LIMIT_W;
   localparam int DEW = TAG_W + DUR_W;
   localparam int FEW = TAG_W + DUR_W + LEVEL_W;

   // Item and configuration
   item_type             item_ff;
   logic [LIMIT_W-1:0]   limit_ff;

   // Queues
   logic [DEW-1:0]       data_mem [DATA_DEPTH];
   logic [FEW-1:0]       fb_mem   [FEEDBACK_DEPTH];
   logic [DEW-1:0]       dq_rd_ff;
   logic [FEW-1:0]       fq_rd_ff;
   logic [DAW-1:0]       dq_head_ff, dq_tail_ff;
   logic [DCW-1:0]       dq_count_ff;
   logic [FAW-1:0]       fq_head_ff, fq_tail_ff;
   logic [FCW-1:0]       fq_count_ff;

   logic [ARR_W-1:0]     arr_ff;
   logic [LEVEL_W-1:0]   level_ff;

   // Result register
   logic                 rsp_valid_ff;
   logic [KIND_W-1:0]    rsp_action_ff;
   logic [TAG_W-1:0]     rsp_tag_ff;
   logic [DUR_W-1:0]     rsp_ticks_ff;
   logic [LEVEL_W-1:0]   rsp_level_ff;

   // Decisions for the item under execution
   logic                 is_data, is_fb, is_service;
   logic                 data_full, fq_room, fq_nonempty, dq_nonempty;
   logic [ARR_W-1:0]     arr_inc;
   logic                 check_due, at_half;
   logic [CW:0]          dq_next_ext;
   logic [LEVEL_W-1:0]   level_up, level_in;
   logic                 level_change;
   logic                 data_push, fb_push, fb_pop, dq_pop;
   logic [FEW-1:0]       fb_wr_data;
   logic                 need_result;

   assign is_data    = (item_ff.kind == KIND_DATA);
   assign is_fb      = (item_ff.kind == KIND_FB);
   assign is_service = (item_ff.kind == KIND_SERVICE);

   // occupancy against min(limit, depth)
   assign data_full = (CW'(dq_count_ff) >= CW'(limit_ff)) ||
                      (CW'(dq_count_ff) >= CW'(DATA_DEPTH));
   assign fq_room     = (fq_count_ff < FCW'(FEEDBACK_DEPTH));
   assign fq_nonempty = (fq_count_ff != '0);
   assign dq_nonempty = (dq_count_ff != '0);

   assign arr_inc     = (arr_ff == ARR_MAX) ? ARR_MAX : arr_ff + 1'b1;
   assign check_due   = (arr_inc > {2'b00, limit_ff[LIMIT_W-1:2]});
   assign dq_next_ext = (CW+1)'(dq_count_ff) + (CW+1)'(1);
   assign at_half     = (dq_next_ext >= (CW+1)'(limit_ff >> 1));
   assign level_up    = (level_ff == LEVEL_MAX) ? LEVEL_MAX : level_ff + 1'b1;

   always_comb begin
      level_change = 1'b0;
      level_in     = level_ff;
      if (is_data && !data_full && check_due) begin
         if (at_half) begin
            level_change = 1'b1;
            level_in     = level_up;
         end else if (level_ff > LEVEL_MIN) begin
            level_change = 1'b1;
            level_in     = level_ff - 1'b1;
         end
      end
   end

   assign data_push = cmd.commit && is_data && !data_full;
   assign fb_push   = cmd.commit && fq_room &&
                      (level_change || (is_fb && (item_ff.level_in >= level_ff)));
   assign fb_pop    = cmd.commit && is_service && fq_nonempty;
   assign dq_pop    = cmd.commit && is_service && !fq_nonempty && dq_nonempty;
   // created feedback carries no tag and no duration
   assign fb_wr_data = is_fb ? {item_ff.level_in, item_ff.duration, item_ff.packet_tag}
                             : {level_in, {DUR_W{1'b0}}, {TAG_W{1'b0}}};

   always_comb begin
      need_result = 1'b0;
      case (item_ff.kind)
         KIND_DATA:    need_result = data_full;
         KIND_SERVICE: need_result = fq_nonempty || dq_nonempty;
         default:      need_result = 1'b0;
      endcase
   end

   assign status.need_result = need_result;
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

   // Item and configuration registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // Queue memories: read the heads every cycle
   always_ff @(posedge clock) begin
      if (data_push) begin
         data_mem[dq_tail_ff] <= {item_ff.duration, item_ff.packet_tag};
      end
      dq_rd_ff <= data_mem[dq_head_ff];
   end

   always_ff @(posedge clock) begin
      if (fb_push) begin
         fb_mem[fq_tail_ff] <= fb_wr_data;
      end
      fq_rd_ff <= fb_mem[fq_head_ff];
   end

   // Pointers, counts, check counter and level
   always_ff @(posedge clock) begin
      if (reset) begin
         dq_head_ff  <= '0;
         dq_tail_ff  <= '0;
         dq_count_ff <= '0;
         fq_head_ff  <= '0;
         fq_tail_ff  <= '0;
         fq_count_ff <= '0;
         arr_ff      <= '0;
         level_ff    <= LEVEL_RESET;
      end else begin
         if (data_push) begin
            dq_tail_ff  <= (dq_tail_ff == DAW'(DATA_DEPTH - 1)) ? '0 : dq_tail_ff + 1'b1;
            dq_count_ff <= dq_count_ff + 1'b1;
         end
         if (dq_pop) begin
            dq_head_ff  <= (dq_head_ff == DAW'(DATA_DEPTH - 1)) ? '0 : dq_head_ff + 1'b1;
            dq_count_ff <= dq_count_ff - 1'b1;
         end
         if (fb_push) begin
            fq_tail_ff  <= (fq_tail_ff == FAW'(FEEDBACK_DEPTH - 1)) ? '0
                                                                    : fq_tail_ff + 1'b1;
            fq_count_ff <= fq_count_ff + 1'b1;
         end
         if (fb_pop) begin
            fq_head_ff  <= (fq_head_ff == FAW'(FEEDBACK_DEPTH - 1)) ? '0
                                                                    : fq_head_ff + 1'b1;
            fq_count_ff <= fq_count_ff - 1'b1;
         end
         if (cmd.commit && is_data) begin
            arr_ff <= (!data_full && check_due) ? '0 : arr_inc;
         end
         if (cmd.commit) begin
            level_ff <= level_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit && need_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && need_result) begin
         if (is_data) begin
            rsp_action_ff <= ACT_DROPPED;
            rsp_tag_ff    <= item_ff.packet_tag;
            rsp_ticks_ff  <= '0;
            rsp_level_ff  <= '0;
         end else if (fq_nonempty) begin
            rsp_action_ff <= ACT_FB_SENT;
            rsp_tag_ff    <= fq_rd_ff[TAG_W-1:0];
            rsp_ticks_ff  <= fq_rd_ff[TAG_W+DUR_W-1:TAG_W];
            rsp_level_ff  <= fq_rd_ff[FEW-1:TAG_W+DUR_W];
         end else begin
            rsp_action_ff <= ACT_DATA_SENT;
            rsp_tag_ff    <= dq_rd_ff[TAG_W-1:0];
            rsp_ticks_ff  <= dq_rd_ff[DEW-1:TAG_W];
            rsp_level_ff  <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_action = rsp_action_ff;
   assign rsp_tag    = rsp_tag_ff;
   assign rsp_ticks  = rsp_ticks_ff;
   assign rsp_level  = rsp_level_ff;

endmodule : rxbcf_datapath
`default_nettype wire

>>> rtl/core/rx_buffer_with_congestion_feedback_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rx_buffer_with_congestion_feedback_core
// Receive-side packet buffer that drops on overflow and raises or lowers a
// service level, queuing feedback packets that report it or that arrive at or above it.
// ----------------------------------------------------------------------------
// Every request item passes through an accept state and an execute state,
// set by the registered read port of the two queue memories (data
// queue of DATA_DEPTH entries, feedback queue of FEEDBACK_DEPTH entries).
// The execute state extends while an item that yields a response finds the
// response register still holding an unsent item; a new request is accepted
// while a finished response waits. Request kinds on req_tuser: data arrival,
// feedback arrival, service complete. A data arrival is dropped (and
// reported) when the data queue holds min(buffer_limit, DATA_DEPTH) packets;
// every arrival is counted, and once the count exceeds buffer_limit/4 the
// occupancy is checked against buffer_limit/2 to move the service level and
// queue a feedback packet. A service complete sends the oldest feedback
// packet first, else the oldest data packet. Both queues come out of reset
// empty; no clearing pass is needed. buffer_limit is written through
// csr_wr_en / csr_wr_data and resets to 200; write it only while idle.
// ----------------------------------------------------------------------------
module rx_buffer_with_congestion_feedback_core #(
   parameter int DATA_DEPTH     = 256,
   parameter int FEEDBACK_DEPTH = 16
) (
   input  wire         clock,
   input  wire         reset,
   // configuration
   input  wire         csr_wr_en,
   input  wire  [8:0]  csr_wr_data,   // buffer_limit
   // request stream
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [55:0] req_tdata,     // packet_tag[31:0], duration[47:32], level_in[55:48]
   input  wire  [1:0]  req_tuser,     // kind[1:0]
   // response stream
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [55:0] rsp_tdata,     // tag_out[31:0], service_ticks[47:32], level_out[55:48]
   output logic [1:0]  rsp_tuser      // action[1:0]
);
   import rxbcf_pkg::*;

   item_type            item;
   cmd_type             cmd;
   status_type          status;
   logic [TAG_W-1:0]    rsp_tag;
   logic [DUR_W-1:0]    rsp_ticks;
   logic [LEVEL_W-1:0]  rsp_level;

   // unpack the request fields
   assign item.kind       = req_tuser;
   assign item.packet_tag = req_tdata[31:0];
   assign item.duration   = req_tdata[47:32];
   assign item.level_in   = req_tdata[55:48];

   rxbcf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rxbcf_datapath #(
      .DATA_DEPTH     (DATA_DEPTH),
      .FEEDBACK_DEPTH (FEEDBACK_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item        (item),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_action  (rsp_tuser),
      .rsp_tag     (rsp_tag),
      .rsp_ticks   (rsp_ticks),
      .rsp_level   (rsp_level)
   );

   // pack the response fields, lowest first
   assign rsp_tdata = {rsp_level, rsp_ticks, rsp_tag};

endmodule : rx_buffer_with_congestion_feedback_core
`default_nettype wire
